// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg
// Types, codes and stage planning for the tree mask decoder.
// ----------------------------------------------------------------------------
package tmd_pkg;

    localparam int NPER     = 4;
    localparam int NPER_LOG = 2;

    typedef enum logic [1:0] {
        CODE_ZERO    = 2'd0,
        CODE_ONE_ZER = 2'd1,
        CODE_ONE_ONE = 2'd2
    } t_code;

    typedef enum int {
        SEL_COUNT = 0,
        SEL_HALF  = 1,
        SEL_FIRST = 2,
        SEL_NODES = 3
    } t_sel;

    localparam logic [1:0] SCHEME_RAW   = 2'd0;
    localparam logic [1:0] SCHEME_LOWER = 2'd1;
    localparam logic [1:0] SCHEME_UPPER = 2'd2;
    localparam logic [1:0] SCHEME_BOTH  = 2'd3;

    typedef struct packed {
        logic [1:0]  scheme;
        logic [31:0] word;
        logic [31:0] mask;
        logic [5:0]  pos;
    } t_work;

    // stage plan: each tree level is cut into chunks of up to NPER nodes
    function automatic int stg_info(int wb, int s, t_sel sel);
        int n;
        int lv;
        int nodes;
        int ch;
        int c;
        int r;
        n = 0;
        r = 0;
        for (lv = 0; (1 << lv) < wb; lv++) begin
            nodes = 1 << lv;
            ch = (nodes + NPER - 1) >> NPER_LOG;
            for (c = 0; c < ch; c++) begin
                if (n == s) begin
                    if (sel == SEL_HALF) r = wb >> (lv + 1);
                    else if (sel == SEL_FIRST) r = c << NPER_LOG;
                    else if (sel == SEL_NODES)
                        r = ((nodes - (c << NPER_LOG)) < NPER) ?
                            (nodes - (c << NPER_LOG)) : NPER;
                end
                n++;
            end
        end
        if (sel == SEL_COUNT) r = n;
        return r;
    endfunction

    // child pair: bit 1 upper half present, bit 0 lower half present
    function automatic logic [1:0] child_pair(logic [1:0] scheme, t_code code);
        logic [1:0] r;
        r = 2'b11;
        case (scheme)
            SCHEME_LOWER: begin
                case (code)
                    CODE_ZERO:    r = 2'b01;
                    CODE_ONE_ZER: r = 2'b10;
                    default:      r = 2'b11;
                endcase
            end
            SCHEME_UPPER: begin
                case (code)
                    CODE_ZERO:    r = 2'b10;
                    CODE_ONE_ZER: r = 2'b01;
                    default:      r = 2'b11;
                endcase
            end
            SCHEME_BOTH: begin
                case (code)
                    CODE_ZERO:    r = 2'b11;
                    CODE_ONE_ZER: r = 2'b01;
                    default:      r = 2'b10;
                endcase
            end
            default: r = 2'b11;
        endcase
        return r;
    endfunction

    // code bit at pos, zero past the end of the word
    function automatic logic read_bit(logic [31:0] w, logic [6:0] pos, int wb);
        logic [6:0] idx;
        idx = 7'(wb - 1) - pos;
        if (pos >= 7'(wb)) return 1'b0;
        return w[idx[4:0]];
    endfunction

endpackage

// ===== hw/rtl/tmd_if.sv =====
// ----------------------------------------------------------------------------
// tmd_if
// Valid/ready channels carrying the input and result words.
// ----------------------------------------------------------------------------
interface tmd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  code_scheme;
    logic [31:0] encoded_bits;
    modport source (output valid, code_scheme, encoded_bits, input ready);
    modport sink   (input valid, code_scheme, encoded_bits, output ready);
endinterface

interface tmd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] decoded_mask;
    logic [5:0]  bits_consumed;
    modport source (output valid, decoded_mask, bits_consumed, input ready);
    modport sink   (input valid, decoded_mask, bits_consumed, output ready);
endinterface

// ===== hw/rtl/tmd_stage.sv =====
// ----------------------------------------------------------------------------
// tmd_stage
// One pipeline stage: decodes up to four nodes of one tree level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmd_stage #(
    parameter int WORD_BITS = 32,
    parameter int HALF      = 16,
    parameter int FIRST     = 0,
    parameter int COUNT     = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tmd_pkg::t_work  i_work,
    output logic            o_ready,
    output logic            o_valid,
    output tmd_pkg::t_work  o_work,
    input  logic            i_ready
);
    tmd_pkg::t_work r_work, n_work;
    logic           r_valid;
    logic           load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        logic [6:0] p;
        logic [1:0] pr;
        logic       b0;
        logic       b1;
        int         top;
        n_work = i_work;
        p  = {1'b0, i_work.pos};
        pr = 2'b11;
        b0 = 1'b0;
        b1 = 1'b0;
        for (int k = 0; k < COUNT; k++) begin
            top = WORD_BITS - 1 - (FIRST + k) * 2 * HALF;
            if (i_work.scheme != tmd_pkg::SCHEME_RAW && n_work.mask[top]) begin
                b0 = tmd_pkg::read_bit(i_work.word, p, WORD_BITS);
                b1 = tmd_pkg::read_bit(i_work.word, p + 7'd1, WORD_BITS);
                if (!b0) begin
                    pr = tmd_pkg::child_pair(i_work.scheme, tmd_pkg::CODE_ZERO);
                    p  = p + 7'd1;
                end else if (!b1) begin
                    pr = tmd_pkg::child_pair(i_work.scheme, tmd_pkg::CODE_ONE_ZER);
                    p  = p + 7'd2;
                end else begin
                    pr = tmd_pkg::child_pair(i_work.scheme, tmd_pkg::CODE_ONE_ONE);
                    p  = p + 7'd2;
                end
                if (!pr[1]) n_work.mask[top - HALF + 1 +: HALF] = '0;
                if (!pr[0]) n_work.mask[top - 2 * HALF + 1 +: HALF] = '0;
            end
        end
        n_work.pos = p[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

    // a stage only ever clears mask bits
    `ASSERT_NEXT(a_mask_shrinks, i_clk, i_rst_n, load,
        (r_work.mask & ~$past(i_work.mask)) == 32'd0)
    // code position never moves backwards
    `ASSERT_NEXT(a_pos_grows, i_clk, i_rst_n, load, r_work.pos >= $past(i_work.pos))

endmodule

// ===== hw/rtl/tree_mask_decode.sv =====
// ----------------------------------------------------------------------------
// tree_mask_decode
// Tree-coded presence mask decoder, one word per cycle unless o_out stalls.
// ----------------------------------------------------------------------------
// Input channel i_in carries code_scheme and encoded_bits (first code bit at
// bit WORD_BITS-1); output channel o_out carries decoded_mask and
// bits_consumed, one result word per input word, in order.
// Each tree level is a pipeline stage, split into stages of up to four nodes
// where the level is wider: 9 stages for WORD_BITS=32, 5 for 16. Throughput
// is one word per cycle while o_out is not stalled.
// Scheme 0 words pass through the same stages untouched.
// Reset clears all stage valid bits; no words are held afterwards.
// A stall on o_out holds the last stage; earlier stages keep filling until
// the pipe is full, then i_in.ready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tree_mask_decode #(
    parameter int WORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tmd_in_if.sink         i_in,
    tmd_out_if.source      o_out
);
    localparam int NSTG = tmd_pkg::stg_info(WORD_BITS, 0, tmd_pkg::SEL_COUNT);
    localparam int LOG  = $clog2(WORD_BITS);
    localparam logic [31:0] FULL = 32'((64'd1 << WORD_BITS) - 64'd1);

    tmd_pkg::t_work w [NSTG+1];
    logic           v [NSTG+1];
    logic           rdy [NSTG+1];

    assign w[0].scheme = i_in.code_scheme;
    assign w[0].word   = i_in.encoded_bits & FULL;
    assign w[0].mask   = (i_in.code_scheme == tmd_pkg::SCHEME_RAW) ?
                         (i_in.encoded_bits & FULL) : FULL;
    assign w[0].pos    = (i_in.code_scheme == tmd_pkg::SCHEME_RAW) ?
                         6'(WORD_BITS) : 6'd0;
    assign v[0]       = i_in.valid;
    assign i_in.ready = rdy[0];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        tmd_stage #(
            .WORD_BITS (WORD_BITS),
            .HALF      (tmd_pkg::stg_info(WORD_BITS, s, tmd_pkg::SEL_HALF)),
            .FIRST     (tmd_pkg::stg_info(WORD_BITS, s, tmd_pkg::SEL_FIRST)),
            .COUNT     (tmd_pkg::stg_info(WORD_BITS, s, tmd_pkg::SEL_NODES))
        ) u_stg (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[s]),
            .i_work  (w[s]),
            .o_ready (rdy[s]),
            .o_valid (v[s+1]),
            .o_work  (w[s+1]),
            .i_ready (rdy[s+1])
        );
    end

    assign rdy[NSTG]           = o_out.ready;
    assign o_out.valid         = v[NSTG];
    assign o_out.decoded_mask  = w[NSTG].mask;
    assign o_out.bits_consumed = w[NSTG].pos;

    // every tree keeps at least one half per node
    `ASSERT_IMPL(a_mask_nonzero, i_clk, i_rst_n,
        v[NSTG] && w[NSTG].scheme != tmd_pkg::SCHEME_RAW, w[NSTG].mask != 32'd0)
    // at least one code bit per level
    `ASSERT_IMPL(a_min_bits, i_clk, i_rst_n,
        v[NSTG] && w[NSTG].scheme != tmd_pkg::SCHEME_RAW, w[NSTG].pos >= 6'(LOG))

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks tree_mask_decode: random and directed words with random gaps on both
// channels, each result compared with a predicted mask and code bit count.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WB = 32;

    typedef struct {
        logic [31:0] mask;
        logic [5:0]  nbits;
    } t_decoded;

    int errors;

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    class mask_scoreboard;
        t_decoded pending[$];

        // bit of the word at code position p, zero past the end
        function automatic logic code_bit(logic [31:0] w, int p);
            if (p >= WB) return 1'b0;
            return w[WB - 1 - p];
        endfunction

        function automatic t_decoded decode_tree(logic [1:0] scheme, logic [31:0] w);
            t_decoded   d;
            logic [1:0] pair;
            int         p;
            int         half;
            int         rp;
            int         k;
            d.mask = '1;
            d.nbits = 6'(WB);
            if (scheme == tmd_pkg::SCHEME_RAW) begin
                d.mask = w;
                return d;
            end
            rp = 0;
            for (half = WB / 2; half >= 1; half = half / 2) begin
                for (p = 0; p + 2 * half <= WB; p += 2 * half) begin
                    if (d.mask[WB - 1 - p]) begin
                        if (!code_bit(w, rp)) begin
                            pair = tmd_pkg::child_pair(scheme, tmd_pkg::CODE_ZERO);
                            rp += 1;
                        end else begin
                            pair = tmd_pkg::child_pair(scheme, code_bit(w, rp + 1) ?
                                   tmd_pkg::CODE_ONE_ONE : tmd_pkg::CODE_ONE_ZER);
                            rp += 2;
                        end
                        for (k = 0; k < half; k++) begin
                            if (!pair[1]) d.mask[WB - 1 - p - k] = 1'b0;
                            if (!pair[0]) d.mask[WB - 1 - p - half - k] = 1'b0;
                        end
                    end
                end
            end
            d.nbits = 6'(rp);
            return d;
        endfunction

        function void note_word(logic [1:0] scheme, logic [31:0] w);
            pending.push_back(decode_tree(scheme, w));
        endfunction

        task check_result(logic [31:0] mask, logic [5:0] nbits);
            t_decoded d;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", mask));
                return;
            end
            d = pending.pop_front();
            if (mask !== d.mask)
                report_mismatch($sformatf("mask %h, want %h", mask, d.mask));
            if (nbits !== d.nbits)
                report_mismatch($sformatf("bits %0d, want %0d", nbits, d.nbits));
        endtask
    endclass

    logic           i_clk;
    logic           i_rst_n;
    tmd_in_if       in_ch();
    tmd_out_if      out_ch();
    mask_scoreboard sb;
    int             idle_cycles;

    tree_mask_decode #(.WORD_BITS(WB)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_word(logic [1:0] scheme, logic [31:0] w);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.code_scheme  <= scheme;
        in_ch.encoded_bits <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(scheme, w);
    endtask

    // sink side: random stall per word, zero for a quarter of the words or more
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            sb.check_result(out_ch.decoded_mask, out_ch.bits_consumed);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] w;
        int          n;
        sb = new();
        errors = 0;
        idle_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.code_scheme = 2'd0;
        in_ch.encoded_bits = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int s = 0; s < 4; s++) begin
            send_word(2'(s), 32'h0);
            send_word(2'(s), 32'hffffffff);
            send_word(2'(s), 32'haaaaaaaa);
            send_word(2'(s), 32'h55555555);
            send_word(2'(s), 32'h80000001);
        end
        in_ch.valid <= 1'b0;
        // wait for the pipe to drain before carrying on
        while (sb.pending.size() != 0) @(posedge i_clk);
        for (n = 0; n < 1330; n++) begin
            case ($urandom_range(0, 3))
                0: w = $urandom();
                1: w = $urandom() & $urandom() & $urandom();
                2: w = $urandom() | $urandom();
                default: w = {8'($urandom_range(0, 255)), 24'h0} | ($urandom() >> 20);
            endcase
            send_word(2'($urandom_range(0, 3)), w);
        end
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tmd_pkg.sv
hw/rtl/tmd_if.sv
hw/rtl/tmd_stage.sv
hw/rtl/tree_mask_decode.sv
tb/sv/testbench.sv
